// ----- src/pwmdfm_pkg.sv -----
`timescale 1ns / 1ps

package pwmdfm_pkg;

    // Channel count and the index width it needs.
    localparam int CHANNELS = 12;
    localparam int IDX_W    = $clog2(CHANNELS);

    // Field widths.
    localparam int CH_W     = 4;
    localparam int TS_W     = 32;
    localparam int RATE_W   = 20;
    localparam int FREQ_W   = 28;
    localparam int DUTY_W   = 15;
    localparam int PROD_W   = DUTY_W + TS_W;
    localparam int M_DATA_W = 112;
    localparam int M_USER_W = CH_W + 1;

    // Reset value of the tick rate and the duty full scale.
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(125000);
    localparam logic [DUTY_W-1:0] DUTY_FULL  = DUTY_W'(25600);

    // Quotient bits produced by the serial divider for each result.
    localparam logic [4:0] FREQ_STEPS = 5'(FREQ_W);
    localparam logic [4:0] DUTY_STEPS = 5'(DUTY_W);

    // Per-channel measurement phase codes.
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_FALL  = 2'd1;
    localparam logic [1:0] PH_CLOSE = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SUM,
        ST_PREP,
        ST_FDIV,
        ST_DDIV,
        ST_DONE
    } t_state;

endpackage

// ----- src/pwm_input_duty_frequency_meter_unit.sv -----
`timescale 1ns / 1ps
// An edge that completes no measurement only updates its channel in the load state. A closing
// edge goes on through sum, prep, the frequency division, the duty division (skipped when the
// duty saturates, both skipped for a zero period) and done, which loads the output register.
// No new edge is taken before the previous one is done, and done waits on an unread result.
// The bit-serial divider makes one quotient bit per cycle, 28 for frequency, 15 for duty.
// Reset (synchronous, active low) clears every channel's phase and loads tick rate 125000.

module pwm_input_duty_frequency_meter_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel: tick rate.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pwmdfm_pkg::RATE_W-1:0]     i_cfg_data,
    // Edge events in.
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [pwmdfm_pkg::TS_W-1:0]       i_s_tdata,  // timestamp
    input  logic [pwmdfm_pkg::CH_W-1:0]       i_s_tuser,  // channel
    // Measurements out.
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // high_ticks, low_ticks, frequency, duty, zero pad
    output logic [pwmdfm_pkg::M_DATA_W-1:0]   o_m_tdata,
    // out_channel, zero_period
    output logic [pwmdfm_pkg::M_USER_W-1:0]   o_m_tuser
);
    import pwmdfm_pkg::*;

    t_state r_state, n_state;

    logic [RATE_W-1:0] r_tick_rate;

    // Per-channel state.
    logic [1:0]      r_phase [CHANNELS];
    logic [TS_W-1:0] r_rise  [CHANNELS];
    logic [TS_W-1:0] r_fall  [CHANNELS];
    logic [TS_W-1:0] r_hspan [CHANNELS];

    // Working registers for the item in progress.
    logic [CH_W-1:0]   r_ch;
    logic [TS_W-1:0]   r_ts;
    logic [TS_W-1:0]   r_high;
    logic [TS_W-1:0]   r_low;
    logic [TS_W-1:0]   r_period;
    logic [PROD_W-1:0] r_prod;
    logic [FREQ_W-1:0] r_freq;
    logic [DUTY_W-1:0] r_duty;
    logic              r_zero;

    // Serial divider registers.
    logic [TS_W-1:0]   r_rem;
    logic [TS_W-1:0]   r_num;
    logic [FREQ_W-1:0] r_quo;
    logic [4:0]        r_cnt;

    // Output register.
    logic              r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    logic [M_USER_W-1:0] r_out_user;

    logic              s_xfer;
    logic              ld_out;
    logic              ch_ok;
    logic [IDX_W-1:0]  idx;

    logic [TS_W:0]     div_trial;
    logic              div_ge;
    logic [TS_W-1:0]   n_rem;
    logic [FREQ_W-1:0] n_quo;

    assign idx   = r_ch[IDX_W-1:0];
    assign ch_ok = (r_ch < CH_W'(CHANNELS));

    // One restoring division step: bring in the next dividend bit and try the subtract.
    always_comb begin
        div_trial = {r_rem, r_num[TS_W-1]};
        div_ge    = (div_trial >= {1'b0, r_period});
        n_rem     = div_ge ? TS_W'(div_trial - {1'b0, r_period}) : div_trial[TS_W-1:0];
        n_quo     = {r_quo[FREQ_W-2:0], div_ge};
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (ch_ok && (r_phase[idx] == PH_CLOSE)) n_state = ST_SUM;
                else n_state = ST_IDLE;
            end
            ST_SUM: n_state = ST_PREP;
            ST_PREP: begin
                if (r_period == '0) n_state = ST_DONE;
                else n_state = ST_FDIV;
            end
            ST_FDIV: begin
                if (r_cnt == 5'd1) begin
                    if (r_high >= r_period) n_state = ST_DONE;
                    else n_state = ST_DDIV;
                end
            end
            ST_DDIV: begin
                if (r_cnt == 5'd1) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake decodes.
    always_comb begin
        o_s_tready  = (r_state == ST_IDLE);
        o_cfg_ready = 1'b1;
        ld_out      = (r_state == ST_DONE) && (!r_out_valid || i_m_tready);
    end

    assign s_xfer = i_s_tvalid && o_s_tready;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tick_rate <= RATE_RESET;
            for (int c = 0; c < CHANNELS; c++) begin
                r_phase[c] <= PH_START;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_tick_rate <= i_cfg_data;
            if ((r_state == ST_LOAD) && ch_ok) begin
                case (r_phase[idx])
                    PH_FALL:  r_phase[idx] <= PH_CLOSE;
                    PH_CLOSE: r_phase[idx] <= PH_START;
                    default:  r_phase[idx] <= PH_FALL;
                endcase
            end
        end
    end

    // Datapath: per-channel stamps, period, product and the serial divider.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (s_xfer) begin
                    r_ch <= i_s_tuser;
                    r_ts <= i_s_tdata;
                end
            end
            ST_LOAD: begin
                if (ch_ok) begin
                    case (r_phase[idx])
                        PH_FALL: begin
                            r_fall[idx]  <= r_ts;
                            r_hspan[idx] <= r_ts - r_rise[idx];
                        end
                        PH_CLOSE: begin
                            r_high <= r_hspan[idx];
                            r_low  <= r_ts - r_fall[idx];
                        end
                        default: r_rise[idx] <= r_ts;
                    endcase
                end
            end
            ST_SUM: begin
                r_period <= r_high + r_low;
                r_prod   <= PROD_W'(DUTY_FULL) * PROD_W'(r_high);
            end
            ST_PREP: begin
                r_zero <= (r_period == '0);
                r_freq <= '0;
                r_duty <= '0;
                r_rem  <= '0;
                r_num  <= {r_tick_rate, 12'b0};
                r_quo  <= '0;
                r_cnt  <= FREQ_STEPS;
            end
            ST_FDIV: begin
                r_rem <= n_rem;
                r_num <= {r_num[TS_W-2:0], 1'b0};
                r_quo <= n_quo;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_freq <= n_quo;
                    // High time at or above the period saturates the duty.
                    if (r_high >= r_period) begin
                        r_duty <= DUTY_FULL;
                    end else begin
                        r_rem <= r_prod[PROD_W-1:DUTY_W];
                        r_num <= {r_prod[DUTY_W-1:0], 17'b0};
                        r_quo <= '0;
                        r_cnt <= DUTY_STEPS;
                    end
                end
            end
            ST_DDIV: begin
                r_rem <= n_rem;
                r_num <= {r_num[TS_W-2:0], 1'b0};
                r_quo <= n_quo;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) r_duty <= n_quo[DUTY_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // Output register: holds a finished measurement until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out_data <= {5'b0, r_duty, r_freq, r_low, r_high};
            r_out_user <= {r_zero, r_ch};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    // The block takes no new edge in the cycle after a transfer.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer |=> !o_s_tready)
        else $error("edge accepted while previous edge still in progress");

    // Duty never exceeds full scale.
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[106:92] <= DUTY_FULL))
        else $error("duty above full scale");

    // A zero period reports zero frequency and duty.
    a_zero_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[CH_W]) |-> (o_m_tdata[106:64] == '0))
        else $error("zero period with nonzero frequency or duty");

    // The divider never runs with an exhausted step count.
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FDIV) || (r_state == ST_DDIV)) |-> (r_cnt != 5'd0))
        else $error("divider step count underflow");

endmodule

// ----- sim/pwm_input_duty_frequency_meter_unit_tb.sv -----
`timescale 1ns / 1ps

module pwm_input_duty_frequency_meter_unit_tb;

    import pwmdfm_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE      = 8;
    localparam int PHASES      = 6;

    // One captured edge and one completed measurement.
    typedef struct {
        logic [CH_W-1:0] ch;
        logic [TS_W-1:0] ts;
    } t_capture;

    typedef struct {
        logic [CH_W-1:0]   ch;
        logic [TS_W-1:0]   high_t;
        logic [TS_W-1:0]   low_t;
        logic [FREQ_W-1:0] freq;
        logic [DUTY_W-1:0] duty;
        logic              zero_p;
    } t_meas;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [RATE_W-1:0]     i_cfg_data  = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [TS_W-1:0]       i_s_tdata   = '0;  // timestamp
    logic [CH_W-1:0]       i_s_tuser   = '0;  // channel
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;         // high_ticks, low_ticks, frequency, duty, pad
    logic [M_USER_W-1:0]   o_m_tuser;         // out_channel, zero_period

    pwm_input_duty_frequency_meter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Edges waiting to be driven and measurements waiting to be seen.
    t_capture capture_queue [$];
    t_meas    expected_meas [$];

    // Predicted meter state.
    logic [RATE_W-1:0] meter_rate                = RATE_RESET;
    logic [1:0]        ch_phase      [CHANNELS]  = '{default: PH_START};
    logic [TS_W-1:0]   ch_rise       [CHANNELS]  = '{default: '0};
    logic [TS_W-1:0]   ch_fall       [CHANNELS]  = '{default: '0};
    logic [TS_W-1:0]   ch_high       [CHANNELS]  = '{default: '0};

    // Generator view of each channel, kept ahead of the block.
    logic [1:0]        gen_phase     [CHANNELS]  = '{default: PH_START};
    logic [TS_W-1:0]   gen_rise      [CHANNELS]  = '{default: '0};
    logic [TS_W-1:0]   gen_last      [CHANNELS]  = '{default: '0};

    int  edges_queued  = 0;
    int  edges_taken   = 0;
    int  meas_checked  = 0;
    int  zero_seen     = 0;
    int  rate_writes   = 0;
    int  fault_count   = 0;
    int  stall_cycles  = 0;
    int  hold_req      = 0;
    int  hold_seen     = 0;
    int  hold_left     = 0;
    int  tx_gap        = 0;
    int  rx_wait       = 0;
    bit  tx_burst      = 1'b0;
    bit  rx_burst      = 1'b0;
    bit  in_taken      = 1'b0;
    bit  out_taken     = 1'b0;

    t_capture drv_item;
    logic     drv_valid;
    logic     rx_ready;
    t_meas    pred_m;
    t_meas    got_m;

    // Advance one channel's machine on an edge; returns 1 when a measurement completes.
    function automatic bit predict_edge(input logic [CH_W-1:0] ch, input logic [TS_W-1:0] ts,
                                        output t_meas m);
        logic [TS_W-1:0] low_t;
        logic [TS_W-1:0] span;
        logic [63:0]     quo;
        m = '{default: '0};
        if (ch >= CHANNELS)
            return 1'b0;
        if (ch_phase[ch] == PH_FALL) begin
            ch_fall[ch]  = ts;
            ch_high[ch]  = ts - ch_rise[ch];
            ch_phase[ch] = PH_CLOSE;
            return 1'b0;
        end
        if (ch_phase[ch] != PH_CLOSE) begin
            ch_rise[ch]  = ts;
            ch_phase[ch] = PH_FALL;
            return 1'b0;
        end
        low_t = ts - ch_fall[ch];
        span  = ch_high[ch] + low_t;
        m.ch     = ch;
        m.high_t = ch_high[ch];
        m.low_t  = low_t;
        if (span == '0) begin
            m.zero_p = 1'b1;
        end else begin
            quo    = (64'(meter_rate) * 64'd256) / 64'(span);
            m.freq = quo[FREQ_W-1:0];
            quo    = (64'(DUTY_FULL) * 64'(ch_high[ch])) / 64'(span);
            // A wrapped period shorter than the high time saturates at full scale.
            if (quo > 64'(DUTY_FULL))
                quo = 64'(DUTY_FULL);
            m.duty = quo[DUTY_W-1:0];
        end
        ch_phase[ch] = PH_START;
        return 1'b1;
    endfunction

    function automatic int field_diff(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
        if (exp_v === act_v)
            return 0;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        return 1;
    endfunction

    // Monitor: predicts on every input transfer and checks every output transfer.
    always @(posedge i_clk) begin
        in_taken  <= i_rst_n && i_s_tvalid && o_s_tready;
        out_taken <= i_rst_n && o_m_tvalid && i_m_tready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                meter_rate = i_cfg_data;
                rate_writes++;
            end
            if (i_s_tvalid && o_s_tready) begin
                edges_taken++;
                if (predict_edge(i_s_tuser, i_s_tdata, pred_m))
                    expected_meas.push_back(pred_m);
            end
            if (o_m_tvalid && i_m_tready) begin
                got_m.high_t = o_m_tdata[31:0];
                got_m.low_t  = o_m_tdata[63:32];
                got_m.freq   = o_m_tdata[91:64];
                got_m.duty   = o_m_tdata[106:92];
                got_m.ch     = o_m_tuser[3:0];
                got_m.zero_p = o_m_tuser[4];
                if (got_m.zero_p)
                    zero_seen++;
                if (expected_meas.size() == 0) begin
                    $display("%0t ns: unexpected measurement on channel %0d", $time, got_m.ch);
                    fault_count++;
                end else begin
                    pred_m = expected_meas.pop_front();
                    meas_checked++;
                    fault_count += field_diff("out_channel", 64'(pred_m.ch), 64'(got_m.ch));
                    fault_count += field_diff("high_ticks", 64'(pred_m.high_t),
                                              64'(got_m.high_t));
                    fault_count += field_diff("low_ticks", 64'(pred_m.low_t),
                                              64'(got_m.low_t));
                    fault_count += field_diff("frequency", 64'(pred_m.freq), 64'(got_m.freq));
                    fault_count += field_diff("duty", 64'(pred_m.duty), 64'(got_m.duty));
                    fault_count += field_diff("zero_period", 64'(pred_m.zero_p),
                                              64'(got_m.zero_p));
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("pwm_input_duty_frequency_meter_unit_tb: errors");
                $finish;
            end
        end
    end

    // Edge driver: takes the next capture once the current one is transferred.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || in_taken) begin
            drv_valid = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (capture_queue.size() > 0) begin
                drv_item  = capture_queue.pop_front();
                drv_valid = 1'b1;
                i_s_tdata <= drv_item.ts;
                i_s_tuser <= drv_item.ch;
                tx_gap    = tx_burst ? 0 : $urandom_range(0, 19);
            end
            i_s_tvalid <= drv_valid;
        end
    end

    // Measurement receiver: random stalls, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (out_taken)
                rx_wait = rx_burst ? 0 : $urandom_range(0, 19);
            rx_ready = 1'b0;
            if (hold_left > 0)
                hold_left--;
            else if (rx_wait > 0)
                rx_wait--;
            else
                rx_ready = 1'b1;
            i_m_tready <= rx_ready;
        end
    end

    // Queue one edge and keep the generator's view of the channel in step.
    task automatic queue_edge(input logic [CH_W-1:0] ch, input logic [TS_W-1:0] ts);
        t_capture c;
        c.ch = ch;
        c.ts = ts;
        capture_queue.push_back(c);
        edges_queued++;
        if (ch < CHANNELS) begin
            gen_last[ch] = ts;
            if (gen_phase[ch] == PH_FALL) begin
                gen_phase[ch] = PH_CLOSE;
            end else if (gen_phase[ch] == PH_CLOSE) begin
                gen_phase[ch] = PH_START;
            end else begin
                gen_rise[ch]  = ts;
                gen_phase[ch] = PH_FALL;
            end
        end
    endtask

    // Random edge: mostly short realistic spacing; wraps, repeats, zero periods, bad channels.
    task automatic queue_random_edge();
        logic [CH_W-1:0] ch;
        logic [TS_W-1:0] ts;
        int              pick;
        if ($urandom_range(0, 19) == 0) begin
            queue_edge(CH_W'($urandom_range(CHANNELS, 15)), $urandom);
        end else begin
            ch   = CH_W'($urandom_range(0, CHANNELS - 1));
            pick = $urandom_range(0, 99);
            if (pick < 55)
                ts = gen_last[ch] + $urandom_range(1, 2000);
            else if (pick < 75)
                ts = gen_last[ch] + $urandom_range(1, 1 << 20);
            else if (pick < 85)
                ts = $urandom;
            else if (pick < 90)
                ts = gen_last[ch];
            else if (gen_phase[ch] == PH_CLOSE)
                ts = gen_rise[ch];
            else
                ts = gen_last[ch] + $urandom_range(1, 300);
            queue_edge(ch, ts);
        end
    endtask

    // Wait until every edge is transferred and every measurement has come back.
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (edges_taken != edges_queued || expected_meas.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] rate);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= rate;
        do
            @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    logic [RATE_W-1:0] phase_rate  [PHASES];
    int                phase_items [PHASES];

    initial begin
        phase_rate  = '{20'd1000000, 20'd1, RATE_W'($urandom_range(1, 1000000)),
                        20'hFFFFF, 20'd0, RATE_W'($urandom_range(1, 1000000))};
        phase_items = '{350, 300, 300, 300, 150, 350};

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed edges at the reset tick rate.
        queue_edge(4'd0, 32'd0);
        queue_edge(4'd0, 32'd100);
        queue_edge(4'd0, 32'd400);
        // Timestamps wrapping through zero.
        queue_edge(4'd11, 32'hFFFF_FFF0);
        queue_edge(4'd11, 32'h0000_0010);
        queue_edge(4'd11, 32'h0000_0030);
        // Closing edge back at the start stamp: the period wraps to zero.
        queue_edge(4'd5, 32'd1000);
        queue_edge(4'd5, 32'd1005);
        queue_edge(4'd5, 32'd1000);
        // Wrapped period shorter than the high time: duty saturates.
        queue_edge(4'd6, 32'h0000_0000);
        queue_edge(4'd6, 32'h9000_0000);
        queue_edge(4'd6, 32'h1000_0000);
        // Channels past the last one are ignored.
        queue_edge(4'd12, 32'hFFFF_FFFF);
        queue_edge(4'd13, 32'h0000_0000);
        queue_edge(4'd14, 32'hAAAA_5555);
        queue_edge(4'd15, 32'h5555_AAAA);
        // Shortest period with zero high time.
        queue_edge(4'd1, 32'd7);
        queue_edge(4'd1, 32'd7);
        queue_edge(4'd1, 32'd8);
        // Longest period.
        queue_edge(4'd2, 32'd0);
        queue_edge(4'd2, 32'hFFFF_FFFE);
        queue_edge(4'd2, 32'hFFFF_FFFF);
        wait_idle();

        // Random phases, each at its own tick rate, the extremes among them.
        for (int p = 0; p < PHASES; p++) begin
            write_rate(phase_rate[p]);
            tx_burst = (p == 1 || p == 3);
            rx_burst = (p == 1);
            for (int n = 0; n < phase_items[p]; n++)
                queue_random_edge();
            if (p == 0) begin
                // Hold off the receiver while edges keep coming so the block backs up.
                @(posedge i_clk);
                hold_req++;
            end
            wait_idle();
        end

        repeat (60) @(negedge i_clk);
        if (expected_meas.size() != 0) begin
            $display("%0t ns: %0d measurements never arrived", $time, expected_meas.size());
            fault_count++;
        end

        $display("Covered %0d edges and %0d measurements (%0d with a zero period)",
                 edges_taken, meas_checked, zero_seen);
        $display("over %0d tick rate settings, with a long output hold-off and input stall.",
                 rate_writes);
        if (fault_count == 0)
            $display("pwm_input_duty_frequency_meter_unit_tb: clean");
        else
            $display("pwm_input_duty_frequency_meter_unit_tb: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/pwmdfm_pkg.sv
src/pwm_input_duty_frequency_meter_unit.sv
sim/pwm_input_duty_frequency_meter_unit_tb.sv
